/* rtl/lmt_pkg.sv */
// ----------------------------------------------------------------------------
// lmt_pkg: shared types and constants of the latency matcher
// Entry and result records, opcode and result kind codes, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package lmt_pkg;

    localparam int DEPTH = 16;

    localparam int KEY_W  = 64;
    localparam int TIME_W = 64;
    localparam int REG_W  = 40;
    localparam int MT_W   = 8;

    localparam logic [REG_W-1:0] TIMEOUT_RST = 40'd30000000000;
    localparam logic [REG_W-1:0] MAX_LAT_RST = 40'd60000000000;

    // opcodes of an input item
    localparam logic [1:0] OP_REQ   = 2'd0;
    localparam logic [1:0] OP_RSP   = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_LAT     = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    // register select: bit 3 of the byte address
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAX_LAT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] sent;
    } entry_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [KEY_W-1:0]  key;
        logic [MT_W-1:0]   mtype;
        logic [TIME_W-1:0] sent;
        logic [TIME_W-1:0] dur;
    } res_t;

    typedef struct packed {
        logic match;
        logic free;
    } scan_flags_t;

endpackage

`default_nettype wire

/* rtl/lmt_cell.sv */
// ----------------------------------------------------------------------------
// lmt_cell: one slot of the pending table
// Holds one entry and passes it to its left neighbor on every shift cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_cell
    import lmt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift_en,
    input  wire entry_t shift_in,
    input  wire logic   wr_en,
    input  wire entry_t wr_data,
    output entry_t      entry
);

    logic              valid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] sent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= wr_data.valid;
        end
        else if (shift_en)
        begin
            valid_reg <= shift_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg  <= wr_data.key;
            sent_reg <= wr_data.sent;
        end
        else if (shift_en)
        begin
            key_reg  <= shift_in.key;
            sent_reg <= shift_in.sent;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.sent  = sent_reg;

endmodule

`default_nettype wire

/* rtl/lmt_head.sv */
// ----------------------------------------------------------------------------
// lmt_head: compare and age unit at the head of the ring
// Matches the entry passing by against the item, works out its latency or
// age, frees it where needed and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_head
    import lmt_pkg::*;
(
    input  wire entry_t            entry_in,
    input  wire logic [1:0]        op,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [TIME_W-1:0] now,
    input  wire logic [MT_W-1:0]   mtype,
    input  wire logic              found,
    input  wire logic [REG_W-1:0]  timeout,
    input  wire logic [REG_W-1:0]  max_lat,
    output entry_t                 entry_out,
    output res_t                   res,
    output scan_flags_t            flags
);

    logic [TIME_W-1:0] diff;
    logic              hit;
    logic              rsp_hit;
    logic              expired;

    assign diff    = now - entry_in.sent;
    assign hit     = entry_in.valid && (entry_in.key == key);
    assign rsp_hit = (op == OP_RSP) && hit && !found;
    assign expired = (op == OP_SWEEP) && entry_in.valid
                     && (diff > {{(TIME_W-REG_W){1'b0}}, timeout});

    assign flags.match = hit;
    assign flags.free  = !entry_in.valid;

    always_comb
    begin
        entry_out = entry_in;
        if (rsp_hit || expired)
        begin
            entry_out.valid = 1'b0;
        end

        res.valid = expired
                    || (rsp_hit && (diff <= {{(TIME_W-REG_W){1'b0}}, max_lat}));
        res.kind  = expired ? KIND_TIMEOUT : KIND_LAT;
        res.key   = entry_in.key;
        res.mtype = expired ? '0 : mtype;
        res.sent  = entry_in.sent;
        res.dur   = diff;
    end

endmodule

`default_nettype wire

/* rtl/request_response_latency_matcher_top.sv */
// ----------------------------------------------------------------------------
// request_response_latency_matcher_top: pending request table with latency
// matching and timeout sweep, built as a rotating ring of entry cells.
// ----------------------------------------------------------------------------
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+-----------------------------
//  item in   | start, busy (taken: start & !busy)| op, key fields, time_ns,
//            |                                   | msg_type
//  result    | strobe (one cycle, no stall)      | kind, out_*, sent_at,
//            |                                   | seen_at, duration_ns, final
//  config    | APB psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
//  Each item goes through the cycle that takes the item, one full rotation
//  of the entry ring past the head unit, and a finish state that inserts a
//  request and releases the last result. busy is high during the rotation
//  and the finish state.
//  Results leave one per cycle at most; the last of an item has final_of_run.
//  Reset empties the table at once and loads the register defaults.
//  The result side has no back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module request_response_latency_matcher_top
    import lmt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic [15:0]        service,
    input  wire logic [15:0]        method,
    input  wire logic [15:0]        client,
    input  wire logic [15:0]        session,
    input  wire logic [TIME_W-1:0]  time_ns,
    input  wire logic [MT_W-1:0]    msg_type,

    output logic                    strobe,
    output logic [1:0]              kind,
    output logic [15:0]             out_service,
    output logic [15:0]             out_method,
    output logic [15:0]             out_client,
    output logic [15:0]             out_session,
    output logic [MT_W-1:0]         out_message_type,
    output logic [TIME_W-1:0]       sent_at,
    output logic [TIME_W-1:0]       seen_at,
    output logic [TIME_W-1:0]       duration_ns,
    output logic                    final_of_run,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [REG_W-1:0] timeout_reg;
    logic [REG_W-1:0] max_lat_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            max_lat_reg <= MAX_LAT_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == REG_TIMEOUT)
            begin
                timeout_reg <= pwdata[REG_W-1:0];
            end
            else
            begin
                max_lat_reg <= pwdata[REG_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[3] == REG_MAX_LAT)
        begin
            prdata = {{(64-REG_W){1'b0}}, max_lat_reg};
        end
        else
        begin
            prdata = {{(64-REG_W){1'b0}}, timeout_reg};
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   scanning;
    logic   finishing;
    logic [IDX_W-1:0] cnt_reg;
    logic   last_step;

    assign accept    = start && !busy;
    assign last_step = (cnt_reg == IDX_W'(TABLE_DEPTH - 1));

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_SCAN : ST_IDLE;
            ST_SCAN:   state_next = last_step ? ST_FINISH : ST_SCAN;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                scanning  = 1'b0;
                finishing = 1'b0;
            end
            ST_SCAN:
            begin
                busy      = 1'b1;
                scanning  = 1'b1;
                finishing = 1'b0;
            end
            ST_FINISH:
            begin
                busy      = 1'b1;
                scanning  = 1'b0;
                finishing = 1'b1;
            end
            default:
            begin
                busy      = 1'b1;
                scanning  = 1'b0;
                finishing = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (scanning)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // item registers
    // ------------------------------------------------------------------
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] time_reg;
    logic [MT_W-1:0]   mtype_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            key_reg   <= {service, method, client, session};
            time_reg  <= time_ns;
            mtype_reg <= msg_type;
        end
    end

    // ------------------------------------------------------------------
    // entry ring: cell 0 faces the head unit, which feeds the last cell
    // ------------------------------------------------------------------
    entry_t      ring     [TABLE_DEPTH];
    entry_t      shin     [TABLE_DEPTH];
    entry_t      head_back;
    entry_t      ins_entry;
    res_t        head_res;
    scan_flags_t head_flags;
    logic        found_reg;
    logic        free_found_reg;
    logic [IDX_W-1:0] free_pos_reg;
    logic        insert;

    assign insert = finishing && (op_reg == OP_REQ) && !found_reg && free_found_reg;

    assign ins_entry.valid = 1'b1;
    assign ins_entry.key   = key_reg;
    assign ins_entry.sent  = time_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign shin[i] = head_back;
        end
        else
        begin : g_mid
            assign shin[i] = ring[i+1];
        end

        lmt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (scanning),
            .shift_in (shin[i]),
            .wr_en    (insert && (free_pos_reg == IDX_W'(i))),
            .wr_data  (ins_entry),
            .entry    (ring[i])
        );
    end

    lmt_head u_head (
        .entry_in  (ring[0]),
        .op        (op_reg),
        .key       (key_reg),
        .now       (time_reg),
        .mtype     (mtype_reg),
        .found     (found_reg),
        .timeout   (timeout_reg),
        .max_lat   (max_lat_reg),
        .entry_out (head_back),
        .res       (head_res),
        .flags     (head_flags)
    );

    // track whether the key is pending and where the lowest free slot is
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (accept)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (scanning)
        begin
            if (head_flags.match)
            begin
                found_reg <= 1'b1;
            end
            if (head_flags.free)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scanning && head_flags.free && !free_found_reg)
        begin
            free_pos_reg <= cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // result staging: hold one result back so the last can be flagged
    // ------------------------------------------------------------------
    res_t hold_reg;
    logic hold_valid_reg;
    logic emit_hold;
    logic emit_full;

    assign emit_hold = hold_valid_reg && ((scanning && head_res.valid) || finishing);
    assign emit_full = finishing && (op_reg == OP_REQ) && !found_reg && !free_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept || finishing)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (scanning && head_res.valid)
        begin
            hold_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scanning && head_res.valid)
        begin
            hold_reg <= head_res;
        end
    end

    logic              strobe_reg;
    logic              strobe_next;
    logic [1:0]        kind_reg;
    logic [1:0]        kind_next;
    logic [KEY_W-1:0]  okey_reg;
    logic [KEY_W-1:0]  okey_next;
    logic [MT_W-1:0]   omt_reg;
    logic [MT_W-1:0]   omt_next;
    logic [TIME_W-1:0] sent_reg;
    logic [TIME_W-1:0] sent_next;
    logic [TIME_W-1:0] seen_reg;
    logic [TIME_W-1:0] dur_reg;
    logic [TIME_W-1:0] dur_next;
    logic              final_reg;
    logic              final_next;

    always_comb
    begin
        strobe_next = emit_hold || emit_full;
        if (emit_full)
        begin
            kind_next  = KIND_FULL;
            okey_next  = key_reg;
            omt_next   = '0;
            sent_next  = '0;
            dur_next   = '0;
            final_next = 1'b1;
        end
        else
        begin
            kind_next  = hold_reg.kind;
            okey_next  = hold_reg.key;
            omt_next   = hold_reg.mtype;
            sent_next  = hold_reg.sent;
            dur_next   = hold_reg.dur;
            final_next = finishing;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (strobe_next)
        begin
            kind_reg  <= kind_next;
            okey_reg  <= okey_next;
            omt_reg   <= omt_next;
            sent_reg  <= sent_next;
            seen_reg  <= time_reg;
            dur_reg   <= dur_next;
            final_reg <= final_next;
        end
    end

    assign strobe           = strobe_reg;
    assign kind             = kind_reg;
    assign out_service      = okey_reg[63:48];
    assign out_method       = okey_reg[47:32];
    assign out_client       = okey_reg[31:16];
    assign out_session      = okey_reg[15:0];
    assign out_message_type = omt_reg;
    assign sent_at          = sent_reg;
    assign seen_at          = seen_reg;
    assign duration_ns      = dur_reg;
    assign final_of_run     = final_reg;

endmodule

`default_nettype wire

/* tb/sv/lmt_checker.sv */
// ----------------------------------------------------------------------------
// lmt_checker: result checker for the request/response latency matcher
// Watches the item, result and register channels, keeps its own copy of the
// pending table and registers, and compares every result against the oldest
// one predicted.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_checker
    import lmt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         op,
    input  wire logic [15:0]        service,
    input  wire logic [15:0]        method,
    input  wire logic [15:0]        client,
    input  wire logic [15:0]        session,
    input  wire logic [TIME_W-1:0]  time_ns,
    input  wire logic [MT_W-1:0]    msg_type,

    input  wire logic               strobe,
    input  wire logic [1:0]         kind,
    input  wire logic [15:0]        out_service,
    input  wire logic [15:0]        out_method,
    input  wire logic [15:0]        out_client,
    input  wire logic [15:0]        out_session,
    input  wire logic [MT_W-1:0]    out_message_type,
    input  wire logic [TIME_W-1:0]  sent_at,
    input  wire logic [TIME_W-1:0]  seen_at,
    input  wire logic [TIME_W-1:0]  duration_ns,
    input  wire logic               final_of_run,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    input  wire logic [63:0]        prdata,
    input  wire logic               pready,

    output int                      fails,
    output int                      pending_count,
    output int                      items_seen,
    output int                      latency_seen,
    output int                      timeout_seen,
    output int                      full_seen
);

    typedef struct packed {
        logic [1:0]        kind;
        logic [KEY_W-1:0]  key;
        logic [MT_W-1:0]   mtype;
        logic [TIME_W-1:0] sent;
        logic [TIME_W-1:0] seen;
        logic [TIME_W-1:0] dur;
        logic              last;
    } match_result_t;

    match_result_t     awaited[$];

    logic              live     [DEPTH];
    logic [KEY_W-1:0]  key_tab  [DEPTH];
    logic [TIME_W-1:0] sent_tab [DEPTH];
    logic [REG_W-1:0]  timeout_reg;
    logic [REG_W-1:0]  max_lat_reg;

    int fail_total = 0;
    int item_total = 0;
    int lat_total  = 0;
    int tmo_total  = 0;
    int full_total = 0;

    initial
    begin
        fails         = 0;
        pending_count = 0;
        items_seen    = 0;
        latency_seen  = 0;
        timeout_seen  = 0;
        full_seen     = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_total++;
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    function automatic void queue_result(input logic [1:0] k, input logic [KEY_W-1:0] key,
                                         input logic [MT_W-1:0] mt,
                                         input logic [TIME_W-1:0] sent,
                                         input logic [TIME_W-1:0] seen,
                                         input logic [TIME_W-1:0] dur);
        match_result_t r;
        r.kind  = k;
        r.key   = key;
        r.mtype = mt;
        r.sent  = sent;
        r.seen  = seen;
        r.dur   = dur;
        r.last  = 1'b0;
        awaited.insert(awaited.size(), r);
    endfunction

    // advance the table copy by one item and queue the results it causes
    task automatic predict_item(input logic [1:0] opc, input logic [KEY_W-1:0] key,
                                input logic [TIME_W-1:0] t, input logic [MT_W-1:0] mt);
        int                hit;
        int                free_slot;
        int                before_cnt;
        logic [TIME_W-1:0] age;

        hit        = -1;
        free_slot  = -1;
        before_cnt = awaited.size();
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit < 0 && live[i] && key_tab[i] == key)
                hit = i;
            if (free_slot < 0 && !live[i])
                free_slot = i;
        end

        case (opc)
            OP_REQ:
            begin
                if (hit < 0)
                begin
                    if (free_slot >= 0)
                    begin
                        live[free_slot]     = 1'b1;
                        key_tab[free_slot]  = key;
                        sent_tab[free_slot] = t;
                    end
                    else
                        queue_result(KIND_FULL, key, '0, '0, t, '0);
                end
            end
            OP_RSP:
            begin
                if (hit >= 0)
                begin
                    age       = t - sent_tab[hit];
                    live[hit] = 1'b0;
                    if (age <= TIME_W'(max_lat_reg))
                        queue_result(KIND_LAT, key, mt, sent_tab[hit], t, age);
                end
            end
            OP_SWEEP:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    age = t - sent_tab[i];
                    if (live[i] && age > TIME_W'(timeout_reg))
                    begin
                        live[i] = 1'b0;
                        queue_result(KIND_TIMEOUT, key_tab[i], '0, sent_tab[i], t, age);
                    end
                end
            end
            default: ;
        endcase

        if (awaited.size() > before_cnt)
            awaited[awaited.size()-1].last = 1'b1;
    endtask

    task automatic check_result();
        match_result_t want;

        if (awaited.size() == 0)
        begin
            report_mismatch("result with nothing pending (kind)", 64'(kind), '0);
            return;
        end
        want = awaited.pop_front();
        case (kind)
            KIND_LAT:     lat_total++;
            KIND_TIMEOUT: tmo_total++;
            KIND_FULL:    full_total++;
            default: ;
        endcase
        if (kind !== want.kind)
            report_mismatch("kind", 64'(kind), 64'(want.kind));
        if (out_service !== want.key[63:48])
            report_mismatch("out_service", 64'(out_service), 64'(want.key[63:48]));
        if (out_method !== want.key[47:32])
            report_mismatch("out_method", 64'(out_method), 64'(want.key[47:32]));
        if (out_client !== want.key[31:16])
            report_mismatch("out_client", 64'(out_client), 64'(want.key[31:16]));
        if (out_session !== want.key[15:0])
            report_mismatch("out_session", 64'(out_session), 64'(want.key[15:0]));
        if (out_message_type !== want.mtype)
            report_mismatch("out_message_type", 64'(out_message_type), 64'(want.mtype));
        if (sent_at !== want.sent)
            report_mismatch("sent_at", sent_at, want.sent);
        if (seen_at !== want.seen)
            report_mismatch("seen_at", seen_at, want.seen);
        if (duration_ns !== want.dur)
            report_mismatch("duration_ns", duration_ns, want.dur);
        if (final_of_run !== want.last)
            report_mismatch("final_of_run", 64'(final_of_run), 64'(want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                live[i] = 1'b0;
            timeout_reg = TIMEOUT_RST;
            max_lat_reg = MAX_LAT_RST;
            awaited.delete();
        end
        else
        begin
            // results of an earlier item come before the next item is taken
            if (strobe)
                check_result();
            if (start && !busy)
            begin
                item_total++;
                predict_item(op, {service, method, client, session},
                             time_ns, msg_type);
            end
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[3] == REG_TIMEOUT)
                        timeout_reg = pwdata[REG_W-1:0];
                    else
                        max_lat_reg = pwdata[REG_W-1:0];
                end
                else if (paddr[3] == REG_TIMEOUT)
                begin
                    if (prdata[REG_W-1:0] !== timeout_reg)
                        report_mismatch("timeout read", 64'(prdata[REG_W-1:0]),
                                        64'(timeout_reg));
                end
                else if (prdata[REG_W-1:0] !== max_lat_reg)
                    report_mismatch("max_latency_ns read", 64'(prdata[REG_W-1:0]),
                                    64'(max_lat_reg));
            end
        end
        pending_count <= awaited.size();
        fails         <= fail_total;
        items_seen    <= item_total;
        latency_seen  <= lat_total;
        timeout_seen  <= tmo_total;
        full_seen     <= full_total;
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the request/response latency matcher
// Resets once, runs a directed sequence through duplicates, wrap-around,
// dropped latencies, a full table and sweeps, then random request/response
// traffic from small key pools under five register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import lmt_pkg::*;
();

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [3:0] ADDR_TIMEOUT = {REG_TIMEOUT, 3'b000};
    localparam logic [3:0] ADDR_MAX_LAT = {REG_MAX_LAT, 3'b000};
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         BATCH_ITEMS  = 61;
    localparam int         POOL_KEYS    = 20;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        op = OP_REQ;
    logic [15:0]       service = '0;
    logic [15:0]       method = '0;
    logic [15:0]       client = '0;
    logic [15:0]       session = '0;
    logic [TIME_W-1:0] time_ns = '0;
    logic [MT_W-1:0]   msg_type = '0;

    logic              strobe;
    logic [1:0]        kind;
    logic [15:0]       out_service;
    logic [15:0]       out_method;
    logic [15:0]       out_client;
    logic [15:0]       out_session;
    logic [MT_W-1:0]   out_message_type;
    logic [TIME_W-1:0] sent_at;
    logic [TIME_W-1:0] seen_at;
    logic [TIME_W-1:0] duration_ns;
    logic              final_of_run;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [63:0]       pwdata = '0;
    logic [63:0]       prdata;
    logic              pready;

    int fails;
    int pending_count;
    int items_seen;
    int latency_seen;
    int timeout_seen;
    int full_seen;

    int items_sent = 0;
    int quiet_cycles = 0;

    request_response_latency_matcher_top dut (.*);
    lmt_checker checker_i (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // end the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results still due",
                     QUIET_LIMIT, pending_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] rand_upto(input logic [63:0] bound);
        logic [63:0] r;
        r = {$urandom, $urandom};
        rand_upto = (bound == '1) ? r : r % (bound + 64'd1);
    endfunction

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [3:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic [1:0] opc, input logic [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] t, input logic [MT_W-1:0] mt);
        int idle_pct;

        idle_pct = (items_sent < 110) ? 17 : (items_sent < 220) ? 64 : 0;
        // idle the sender cycle by cycle before offering the item
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        op       <= opc;
        service  <= key[63:48];
        method   <= key[47:32];
        client   <= key[31:16];
        session  <= key[15:0];
        time_ns  <= t;
        msg_type <= mt;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    // wait out all results, then the scan of an item that causes none
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
    endtask

    task automatic run_directed();
        logic [KEY_W-1:0] fill_key;

        send_item(OP_REQ, '0, '0, '0);
        send_item(OP_REQ, '1, 64'hFFFF_FFFF_FFFF_FFF0, 8'hFF);
        // duplicate key keeps the first send time
        send_item(OP_REQ, '0, 64'd100, 8'h00);
        send_item(OP_RSP, 64'h0001_0002_0003_0004, 64'd5, 8'h5A);
        // receive time wrapped past zero
        send_item(OP_RSP, '1, 64'h10, 8'hFF);
        // latency just above the limit: freed, no result
        send_item(OP_RSP, '0, 64'd60_000_000_001, 8'h00);
        send_item(OP_UNUSED, '1, '1, 8'hFF);
        for (int i = 0; i < DEPTH; i++)
        begin
            fill_key = {16'(i), 16'hA5A5, ~16'(i), 16'h5A5A};
            send_item(OP_REQ, fill_key, 64'd1000 + 64'(i), 8'($urandom));
        end
        send_item(OP_REQ, {16'hFFFF, 16'h0000, 16'h0000, 16'h0001}, 64'd2000, 8'h33);
        // half the entries are past the timeout, one sits exactly on it
        send_item(OP_SWEEP, '0, 64'd30_000_001_008, 8'($urandom));
        send_item(OP_SWEEP, '1, 64'd40_000_000_000, 8'($urandom));
        send_item(OP_SWEEP, '0, 64'd80_000_000_000, 8'($urandom));
    endtask

    task automatic run_batch(input logic [63:0] scale);
        logic [KEY_W-1:0]  pool [POOL_KEYS];
        logic [1:0]        noise_ops [3];
        logic [TIME_W-1:0] now;
        logic [KEY_W-1:0]  k;
        int                done;
        int                pick;

        noise_ops[0] = OP_REQ;
        noise_ops[1] = OP_RSP;
        noise_ops[2] = OP_SWEEP;
        for (int i = 0; i < POOL_KEYS; i++)
            pool[i] = {$urandom, $urandom};
        now  = {$urandom, $urandom};
        done = 0;
        while (done < BATCH_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            k    = pool[$urandom_range(0, POOL_KEYS - 1)];
            if ($urandom_range(0, 3) != 0)
                now = now + rand_upto(scale);
            if (pick < 45)
                send_item(OP_REQ, k, now, 8'($urandom));
            else if (pick < 80)
                send_item(OP_RSP, k, now, 8'($urandom));
            else if (pick < 92)
                send_item(OP_SWEEP, {$urandom, $urandom}, now, 8'($urandom));
            else if (pick < 97)
                send_item(noise_ops[$urandom_range(0, 2)], {$urandom, $urandom},
                          {$urandom, $urandom}, 8'($urandom));
            else
            begin
                send_item(OP_UNUSED, {$urandom, $urandom}, {$urandom, $urandom},
                          8'($urandom));
                continue;
            end
            done++;
        end
    endtask

    initial
    begin
        logic [63:0] wide_timeout;
        logic [63:0] wide_max_lat;
        logic [63:0] scale;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read(ADDR_TIMEOUT);
        apb_read(ADDR_MAX_LAT);
        run_directed();

        for (int setting = 0; setting < 5; setting++)
        begin
            if (setting > 0)
                drain();
            case (setting)
                0:  scale = 64'd20_000_000_000;
                1:
                begin
                    apb_write(ADDR_TIMEOUT, '0);
                    apb_write(ADDR_MAX_LAT, '0);
                    scale = 64'd3;
                end
                2:
                begin
                    apb_write(ADDR_TIMEOUT, 64'hFF_FFFF_FFFF);
                    apb_write(ADDR_MAX_LAT, 64'hFF_FFFF_FFFF);
                    scale = 64'h7F_FFFF_FFFF;
                end
                3:
                begin
                    apb_write(ADDR_TIMEOUT, 64'($urandom_range(100, 5000)));
                    apb_write(ADDR_MAX_LAT, 64'($urandom_range(100, 5000)));
                    scale = 64'd2000;
                end
                default:
                begin
                    // upper bits set on purpose: only the low 40 are kept
                    wide_timeout = {$urandom, $urandom};
                    wide_max_lat = {$urandom, $urandom};
                    apb_write(ADDR_TIMEOUT, wide_timeout);
                    apb_write(ADDR_MAX_LAT, wide_max_lat);
                    scale = 64'(wide_timeout[REG_W-1:1]) + 64'd1;
                end
            endcase
            if (setting > 0)
            begin
                apb_read(ADDR_TIMEOUT);
                apb_read(ADDR_MAX_LAT);
            end
            run_batch(scale);
        end
        drain();

        $display("Ran %0d items over five register settings, from zero limits to full scale",
                 items_seen);
        $display("Checked %0d latency, %0d timeout and %0d table-full results",
                 latency_seen, timeout_seen, full_seen);
        if (fails == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
